// ===== rtl/mdcks_pkg.sv =====
// Shared types and constants for the buffer checksum block.
// Used by every module under rtl/ except mdcks_fifo; depends on nothing else.
`default_nettype none
package mdcks_pkg;

   // Seed for the running sum and for each djb2 pass
   localparam logic [63:0] SEED_VALUE = 64'd5381;
   // Murmur3 fmix32 multipliers
   localparam logic [31:0] FMIX_MUL1 = 32'h85eb_ca6b;
   localparam logic [31:0] FMIX_MUL2 = 32'hc2b2_ae35;
   // Default queue depths
   localparam int QUEUE_DEPTH_DEF  = 2;
   localparam int RESULT_DEPTH_DEF = 2;

   // How the back end treats a word
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,   // no valid bytes
      KIND_FULL = 2'd1,   // eight or more bytes: fmix32 of low half
      KIND_PART = 2'd2    // one to seven bytes: djb2
   } kind_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic [63:0] data;
      kind_type    kind;
      logic [2:0]  count;
      logic        last;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_MIX1 = 3'd1,
      ST_MIX2 = 3'd2,
      ST_MIX3 = 3'd3,
      ST_DJB  = 3'd4,
      ST_FIN  = 3'd5
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/murmur_djb2_buffer_checksum_unit.sv =====
// Top level of the buffer checksum block.
// Depends on mdcks_pkg, mdcks_front, mdcks_back and mdcks_fifo.
//
//   Channel   Ports                                   Handshake
//   input     req_data_word req_byte_count req_last   req_push / req_full
//   result    rsp_checksum_value                      rsp_pop / rsp_empty
//
// The back-end sequencer sets the rate: IDLE, MIX1-MIX3, FIN for a full
// word; IDLE, a DJB step per byte, FIN for a partial one; IDLE, FIN if empty.
// The input queue keeps accepting until full while the sequencer works; the
// result queue lets results wait for rsp_pop, stalling FIN only when full.
// Synchronous active-high reset empties both queues and sets the sum to 5381.
`default_nettype none
module murmur_djb2_buffer_checksum_unit #(
   parameter int QUEUE_DEPTH  = mdcks_pkg::QUEUE_DEPTH_DEF,
   parameter int RESULT_DEPTH = mdcks_pkg::RESULT_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [63:0]      rsp_checksum_value
);
   mdcks_pkg::item_type q_item;
   logic                q_empty;
   logic                q_pop;
   logic                res_full;
   logic                res_push;
   logic [63:0]         res_data;

   mdcks_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .q_empty        (q_empty)
   );

   mdcks_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_item),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res_data (res_data)
   );

   // result queue
   mdcks_fifo #(
      .WIDTH (64),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_checksum_value),
      .empty     (rsp_empty)
   );

`ifndef SYNTHESIS
   // sequencer only pops a queue that holds an item
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty input queue");

   // sequencer never pushes into a full result queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   // a pushed result is visible on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !rsp_empty)
      else $error("pushed result not visible");

   // each pop takes the sequencer out of IDLE, so no two pops are consecutive
   a_no_back_to_back_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("input queue popped on consecutive cycles");
`endif

endmodule
`default_nettype wire

// ===== rtl/mdcks_fifo.sv =====
// Small show-ahead queue built from registers.
// Generic; no package dependency.
`default_nettype none
module mdcks_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mdcks_front.sv =====
// Front end: accepts input words, classifies them and queues them.
// Depends on mdcks_pkg and mdcks_fifo.
`default_nettype none
module mdcks_front #(
   parameter int QUEUE_DEPTH = mdcks_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [63:0]        req_data_word,
   input  wire logic [3:0]         req_byte_count,
   input  wire logic               req_last,
   input  wire logic               q_pop,
   output mdcks_pkg::item_type     q_item,
   output logic                    q_empty
);
   mdcks_pkg::item_type cls_item;
   logic [$bits(mdcks_pkg::item_type)-1:0] q_bits;

   // classify by byte count; counts of eight and above are full words
   always_comb begin
      cls_item.data  = req_data_word;
      cls_item.count = req_byte_count[2:0];
      cls_item.last  = req_last;
      if (req_byte_count[3]) begin
         cls_item.kind = mdcks_pkg::KIND_FULL;
      end else if (req_byte_count[2:0] == 3'd0) begin
         cls_item.kind = mdcks_pkg::KIND_NONE;
      end else begin
         cls_item.kind = mdcks_pkg::KIND_PART;
      end
   end

   mdcks_fifo #(
      .WIDTH ($bits(mdcks_pkg::item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_bits),
      .empty     (q_empty)
   );

   assign q_item = mdcks_pkg::item_type'(q_bits);

endmodule
`default_nettype wire

// ===== rtl/mdcks_back.sv =====
// Back end: sequencer that folds each queued item into the running sum.
// Depends on mdcks_pkg.
`default_nettype none
module mdcks_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mdcks_pkg::item_type q_item,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic                res_full,
   output logic                     res_push,
   output logic [63:0]              res_data
);
   mdcks_pkg::state_type state_ff, state_in;
   logic [63:0] data_ff, data_in;
   logic [31:0] x_ff, x_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] sum_ff, sum_in;
   logic [2:0]  left_ff, left_in;
   logic        last_ff, last_in;
   logic [63:0] h_step;
   logic [31:0] x_xor13;
   logic [31:0] lo_word;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdcks_pkg::ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_item.kind)
                  mdcks_pkg::KIND_FULL: state_in = mdcks_pkg::ST_MIX1;
                  mdcks_pkg::KIND_PART: state_in = mdcks_pkg::ST_DJB;
                  default:              state_in = mdcks_pkg::ST_FIN;
               endcase
            end
         end
         mdcks_pkg::ST_MIX1: state_in = mdcks_pkg::ST_MIX2;
         mdcks_pkg::ST_MIX2: state_in = mdcks_pkg::ST_MIX3;
         mdcks_pkg::ST_MIX3: state_in = mdcks_pkg::ST_FIN;
         mdcks_pkg::ST_DJB: begin
            if (left_ff == 3'd0) begin
               state_in = mdcks_pkg::ST_FIN;
            end
         end
         mdcks_pkg::ST_FIN: begin
            if (!last_ff || !res_full) begin
               state_in = mdcks_pkg::ST_IDLE;
            end
         end
         default: state_in = mdcks_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      q_pop    = (state_ff == mdcks_pkg::ST_IDLE) && !q_empty;
      res_push = (state_ff == mdcks_pkg::ST_FIN) && last_ff && !res_full;
      res_data = sum_ff;
   end

   // djb2 step on the low byte: h * 33 + signed byte
   assign h_step  = (h_ff << 5) + h_ff + {{56{data_ff[7]}}, data_ff[7:0]};
   assign x_xor13 = x_ff ^ (x_ff >> 13);
   assign lo_word = q_item.data[31:0];

   // datapath
   always_comb begin
      data_in = data_ff;
      x_in    = x_ff;
      h_in    = h_ff;
      sum_in  = sum_ff;
      left_in = left_ff;
      last_in = last_ff;
      unique case (state_ff)
         mdcks_pkg::ST_IDLE: begin
            if (!q_empty) begin
               data_in = q_item.data;
               last_in = q_item.last;
               x_in    = lo_word ^ (lo_word >> 16);
               h_in    = mdcks_pkg::SEED_VALUE;
               left_in = q_item.count - 3'd1;
            end
         end
         mdcks_pkg::ST_MIX1: x_in = x_ff * mdcks_pkg::FMIX_MUL1;
         mdcks_pkg::ST_MIX2: x_in = x_xor13 * mdcks_pkg::FMIX_MUL2;
         mdcks_pkg::ST_MIX3: sum_in = sum_ff ^ {32'd0, x_ff ^ (x_ff >> 16)};
         mdcks_pkg::ST_DJB: begin
            h_in    = h_step;
            data_in = data_ff >> 8;
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd0) begin
               sum_in = sum_ff ^ h_step;
            end
         end
         mdcks_pkg::ST_FIN: begin
            if (res_push) begin
               sum_in = mdcks_pkg::SEED_VALUE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdcks_pkg::ST_IDLE;
         sum_ff   <= mdcks_pkg::SEED_VALUE;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      x_ff    <= x_in;
      h_ff    <= h_in;
      left_ff <= left_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the buffer checksum unit.
// Depends on mdcks_pkg and murmur_djb2_buffer_checksum_unit; a local model folds
// each word and every checksum popped from the result queue is compared in order.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   // Run limits and receiver hold-off length
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 60;
   localparam int HOLD_AT_1    = 30;
   localparam int HOLD_AT_2    = 400;

   // One buffer word as offered on the input channel
   typedef struct {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
   } word_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_checksum_value;

   word_item_type words_to_send[$];
   logic [63:0]   expected_sums[$];
   word_item_type sent_word;
   word_item_type next_word;
   logic [63:0] model_sum = mdcks_pkg::SEED_VALUE;
   logic        quiet_tail = 1'b0;
   int          send_gap = 0;
   int          pop_gap = 0;
   int          hold_left = 0;
   int          holds_done = 0;
   int          cycle_count = 0;
   int          error_count = 0;
   int          words_accepted = 0;
   int          partial_words = 0;
   int          sums_checked = 0;

   murmur_djb2_buffer_checksum_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last           (req_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_checksum_value (rsp_checksum_value)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Murmur3 32-bit finalizer, zero-extended
   function automatic logic [63:0] fmix32_value(logic [31:0] v);
      logic [31:0] x;
      x = v;
      x = x ^ (x >> 16);
      x = x * mdcks_pkg::FMIX_MUL1;
      x = x ^ (x >> 13);
      x = x * mdcks_pkg::FMIX_MUL2;
      x = x ^ (x >> 16);
      return {32'd0, x};
   endfunction

   // 64-bit djb2 over the low n bytes, bytes taken as signed chars
   function automatic logic [63:0] djb2_value(logic [63:0] w, logic [3:0] n);
      logic [63:0] h;
      logic [63:0] b;
      int          i;
      h = mdcks_pkg::SEED_VALUE;
      for (i = 0; i < 8; i++) begin
         if (i < n) begin
            b = {{56{w[8*i+7]}}, w[8*i +: 8]};
            h = (h << 5) + h + b;
         end
      end
      return h;
   endfunction

   // Fold one accepted word into the running sum; a last word yields a checksum
   task automatic fold_word(word_item_type it);
      if (it.count >= 4'd8)
         model_sum = model_sum ^ fmix32_value(it.word[31:0]);
      else if (it.count != 4'd0) begin
         model_sum = model_sum ^ djb2_value(it.word, it.count);
         partial_words++;
      end
      if (it.last) begin
         expected_sums.push_back(model_sum);
         model_sum = mdcks_pkg::SEED_VALUE;
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH @%0d: %s got %h want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic queue_word(logic [63:0] w, logic [3:0] n, logic l);
      word_item_type it;
      it.word  = w;
      it.count = n;
      it.last  = l;
      words_to_send.push_back(it);
   endtask

   // Random data with some all-zero and all-one words mixed in
   function automatic logic [63:0] random_data();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom(), $urandom()};
   endfunction

   // Mostly well-formed buffers, some noise words and broken buffers
   task automatic queue_random_buffers(int budget);
      int added;
      int kind;
      int nfull;
      int i;
      added = 0;
      while (added < budget) begin
         kind = $urandom_range(0, 9);
         if (kind <= 7) begin
            nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16)
                                                : $urandom_range(0, 4);
            for (i = 0; i < nfull; i++) begin
               // occasionally an oversized count on a full word
               if ($urandom_range(0, 7) == 0)
                  queue_word(random_data(), 4'($urandom_range(9, 15)), 1'b0);
               else
                  queue_word(random_data(), 4'd8, 1'b0);
            end
            queue_word(random_data(), 4'($urandom_range(0, 8)), 1'b1);
            added += nfull + 1;
         end else if (kind == 8) begin
            // noise: anything the fields allow
            queue_word(random_data(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            added++;
         end else begin
            // broken buffer: partial or empty words in the middle
            queue_word(random_data(), 4'd8, 1'b0);
            queue_word(random_data(), 4'($urandom_range(0, 7)), 1'b0);
            queue_word(random_data(), 4'($urandom_range(0, 15)), 1'b1);
            added += 3;
         end
      end
   endtask

   // Sender pause: wait until everything offered is in and every checksum is out
   task automatic wait_for_drain();
      @(negedge clock);
      while (words_to_send.size() != 0 || req_push || expected_sums.size() != 0)
         @(negedge clock);
   endtask

   // Driver: offers queued words, with random gaps outside the tail
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_push && !req_full) begin
            sent_word.word  = req_data_word;
            sent_word.count = req_byte_count;
            sent_word.last  = req_last;
            fold_word(sent_word);
            words_accepted++;
         end
         if (req_push && req_full) begin
            // hold the item until the block takes it
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_push <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            send_gap <= $urandom_range(0, 5);
            req_push <= 1'b0;
         end else if (words_to_send.size() != 0) begin
            next_word = words_to_send.pop_front();
            req_data_word  <= next_word.word;
            req_byte_count <= next_word.count;
            req_last       <= next_word.last;
            req_push       <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: pops checksums and compares them in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         pop_gap   <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_sums.size() == 0)
               report_mismatch("unexpected checksum", rsp_checksum_value, '0);
            else if (rsp_checksum_value !== expected_sums[0])
               report_mismatch("checksum_value", rsp_checksum_value, expected_sums[0]);
            if (expected_sums.size() != 0)
               void'(expected_sums.pop_front());
            sums_checked++;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if ((holds_done == 0 && sums_checked >= HOLD_AT_1) ||
                      (holds_done == 1 && sums_checked >= HOLD_AT_2)) begin
            // long hold-off so both queues fill and the input stalls
            holds_done++;
            hold_left <= HOLD_CYCLES - 1;
            rsp_pop   <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            pop_gap <= $urandom_range(0, 5);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Stimulus phases and end of run
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words: extremes, signed bytes, saturation, empty and partial words
      queue_word('0, 4'd8, 1'b0);
      queue_word('1, 4'd8, 1'b1);
      queue_word('0, 4'd0, 1'b1);
      queue_word(64'h0000_0000_0000_0080, 4'd1, 1'b1);
      queue_word(64'h0000_0000_0000_007f, 4'd1, 1'b1);
      queue_word('1, 4'd7, 1'b1);
      queue_word('1, 4'd15, 1'b1);
      queue_word(64'h0123_4567_89ab_cdef, 4'd9, 1'b0);
      queue_word(64'hfedc_ba98_7654_3210, 4'd3, 1'b0);
      queue_word(64'h5555_aaaa_5555_aaaa, 4'd0, 1'b0);
      queue_word(64'h8000_0000_8000_0000, 4'd8, 1'b1);
      queue_word(64'hffff_ffff_ffff_0102, 4'd2, 1'b1);
      queue_word(64'h0000_0000_8080_8080, 4'd4, 1'b1);
      queue_word(64'h7f80_7f80_7f80_7f80, 4'd5, 1'b1);
      queue_word(64'h00ff_00ff_00ff_00ff, 4'd6, 1'b1);
      queue_word('0, 4'd7, 1'b1);
      queue_word(64'hffff_ffff_0000_0000, 4'd8, 1'b0);
      queue_word(64'h0000_0000_ffff_ffff, 4'd12, 1'b0);
      queue_word('1, 4'd8, 1'b0);
      queue_word(64'h1234_5678_9abc_def0, 4'd7, 1'b1);
      wait_for_drain();

      queue_random_buffers(350);
      wait_for_drain();

      queue_random_buffers(350);
      wait_for_drain();

      // closing part runs without idling on either side
      quiet_tail = 1'b1;
      queue_random_buffers(150);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_sums.size() != 0)
         report_mismatch("checksums never delivered", 64'(expected_sums.size()), '0);

      $display("Run covered %0d words (%0d partial) and %0d checksums,",
               words_accepted, partial_words, sums_checked);
      $display("with %0d long receiver hold-offs and sender drain pauses.", holds_done);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

// ===== murmur_djb2_buffer_checksum_unit.f =====
rtl/mdcks_pkg.sv
rtl/mdcks_fifo.sv
rtl/mdcks_front.sv
rtl/mdcks_back.sv
rtl/murmur_djb2_buffer_checksum_unit.sv
tb/testbench.sv
